// ===== rtl/hfch_pkg.sv =====
// Shared constants, types and reply tables for the host frame command handler.
`timescale 1ns / 1ps
`default_nettype none
package hfch_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int SRC_BYTES   = 11;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int OUT_W       = $clog2(FRAME_BYTES + SRC_BYTES);
   localparam int RELAY_W     = 6;
   localparam int SET_W       = 16;

   localparam logic [IDX_W-1:0] LAST_FRAME_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] CODE_IDX       = IDX_W'(3);
   localparam logic [IDX_W-1:0] SEQ_IDX        = IDX_W'(2);
   localparam logic [IDX_W-1:0] HI_IDX         = IDX_W'(4);
   localparam logic [IDX_W-1:0] LO_IDX         = IDX_W'(5);
   localparam logic [IDX_W-1:0] FLAG_IDX       = IDX_W'(12);
   localparam logic [OUT_W-1:0] LAST_HOST_OUT  = OUT_W'(FRAME_BYTES - 1);
   localparam logic [OUT_W-1:0] LAST_SRC_OUT   = OUT_W'(FRAME_BYTES + SRC_BYTES - 1);

   localparam logic [7:0] START_BYTE = 8'hFE;
   localparam logic [7:0] LEN_BYTE   = 8'h10;
   localparam logic [7:0] END_BYTE   = 8'hFF;
   localparam logic [7:0] FLAG_BYTE  = 8'h01;

   localparam logic [7:0] CODE_D5 = 8'hD5;
   localparam logic [7:0] CODE_D6 = 8'hD6;
   localparam logic [7:0] CODE_B1 = 8'hB1;
   localparam logic [7:0] CODE_B2 = 8'hB2;
   localparam logic [7:0] CODE_B3 = 8'hB3;
   localparam logic [7:0] CODE_A9 = 8'hA9;
   localparam logic [7:0] CODE_AA = 8'hAA;
   localparam logic [7:0] CODE_C2 = 8'hC2;
   localparam logic [7:0] CODE_C3 = 8'hC3;
   localparam logic [7:0] CODE_C4 = 8'hC4;
   localparam logic [7:0] CODE_C5 = 8'hC5;

   localparam logic [7:0] TIMEOUT_RESET = 8'd5;
   localparam logic [RELAY_W-1:0] RELAY_RESET = 6'h08;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_D5   = 2'd1;
   localparam logic [1:0] KIND_D6   = 2'd2;

   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_ON   = 2'd1;
   localparam logic [1:0] SRC_OFF  = 2'd2;

   typedef struct packed {
      logic             start;
      logic             store;
      logic             finish;
      logic             load;
      logic             last;
      logic [IDX_W-1:0] wr_idx;
      logic [OUT_W-1:0] out_idx;
   } hfch_cmd_type;

   typedef struct packed {
      logic out_free;
      logic has_src;
   } hfch_status_type;

   // source link enable / disable command bytes
   function automatic logic [7:0] src_byte(input logic [IDX_W-1:0] idx, input logic off);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0:    b = 8'h02;
         4'd1:    b = 8'h45;
         4'd2:    b = 8'h4E;
         4'd3:    b = 8'h42;
         4'd4:    b = 8'h4C;
         4'd5:    b = 8'h20;
         4'd6:    b = off ? 8'h30 : 8'h31;
         4'd7:    b = 8'h3B;
         4'd8:    b = off ? 8'h54 : 8'h53;
         4'd9:    b = 8'h0D;
         4'd10:   b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hfch_req_if.sv =====
// Request channel interface: host bytes and millisecond ticks.
`timescale 1ns / 1ps
`default_nettype none
interface hfch_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;
   logic [7:0] switch_raw;

   modport source (output valid, output req_type, output rx_byte, output switch_raw,
                   input ready);
   modport sink (input valid, input req_type, input rx_byte, input switch_raw,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/hfch_rsp_if.sv =====
// Response channel interface: transmitted bytes with relay and setpoint state.
`timescale 1ns / 1ps
`default_nettype none
interface hfch_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tx_byte;
   logic        tx_port;
   logic        last_byte;
   logic [5:0]  relay_bits;
   logic [15:0] voltage_setpoint;
   logic [15:0] current_setpoint;

   modport source (output valid, output tx_byte, output tx_port, output last_byte,
                   output relay_bits, output voltage_setpoint, output current_setpoint,
                   input ready);
   modport sink (input valid, input tx_byte, input tx_port, input last_byte,
                 input relay_bits, input voltage_setpoint, input current_setpoint,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/hfch_datapath.sv =====
// Frame store, command decode, relay/setpoint registers and response output register.
`timescale 1ns / 1ps
`default_nettype none
module hfch_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [7:0]               switch_raw,
   input  wire hfch_pkg::hfch_cmd_type   cmd,
   output      hfch_pkg::hfch_status_type status,
   hfch_rsp_if.source                    rsp
);
   import hfch_pkg::*;

   logic [7:0]         frame_ff [FRAME_BYTES];
   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         src_ff, src_in;
   logic [3:0]         sw_ff;
   logic [RELAY_W-1:0] relay_ff, relay_in;
   logic [SET_W-1:0]   volt_ff, volt_in;
   logic [SET_W-1:0]   curr_ff, curr_in;

   logic               valid_ff;
   logic [7:0]         byte_ff, byte_in;
   logic               port_ff, last_ff;
   logic [RELAY_W-1:0] out_relay_ff;
   logic [SET_W-1:0]   out_volt_ff, out_curr_ff;

   logic [7:0]         code;
   logic [SET_W-1:0]   setval;
   logic [IDX_W-1:0]   oidx;

   assign code   = frame_ff[CODE_IDX];
   assign setval = {frame_ff[HI_IDX], frame_ff[LO_IDX]};
   assign oidx   = cmd.out_idx[IDX_W-1:0];

   always_comb begin
      kind_in  = KIND_ECHO;
      src_in   = SRC_NONE;
      relay_in = relay_ff;
      volt_in  = volt_ff;
      curr_in  = curr_ff;
      case (code)
         CODE_D5: kind_in = KIND_D5;
         CODE_D6: kind_in = KIND_D6;
         CODE_B1: relay_in[1:0] = 2'b01;
         CODE_B2: relay_in[1:0] = 2'b10;
         CODE_B3: relay_in[1:0] = 2'b00;
         CODE_A9: relay_in[2] = 1'b1;
         CODE_AA: relay_in[2] = 1'b0;
         CODE_C4: begin
            relay_in[5:4] = 2'b11;
            src_in = SRC_ON;
         end
         CODE_C5: begin
            relay_in[5:4] = 2'b00;
            src_in = SRC_OFF;
         end
         CODE_C2: volt_in = setval;
         CODE_C3: curr_in = setval;
         default: kind_in = KIND_ECHO;
      endcase
   end

   always_comb begin
      byte_in = 8'h00;
      if (cmd.out_idx > LAST_HOST_OUT) begin
         byte_in = src_byte(oidx, src_ff == SRC_OFF);
      end else if (kind_ff == KIND_ECHO) begin
         byte_in = (oidx == FLAG_IDX) ? FLAG_BYTE : frame_ff[oidx];
      end else begin
         case (oidx)
            4'd0:    byte_in = START_BYTE;
            4'd1:    byte_in = LEN_BYTE;
            4'd2:    byte_in = frame_ff[SEQ_IDX];
            4'd3:    byte_in = (kind_ff == KIND_D6) ? CODE_D6 : 8'h00;
            4'd5:    byte_in = (kind_ff == KIND_D5) ? {4'h0, sw_ff} : 8'h00;
            4'd12:   byte_in = FLAG_BYTE;
            4'd15:   byte_in = END_BYTE;
            default: byte_in = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         frame_ff[0] <= START_BYTE;
      end else if (cmd.store) begin
         frame_ff[cmd.wr_idx] <= rx_byte;
      end
      if (cmd.finish) begin
         kind_ff <= kind_in;
         src_ff  <= src_in;
         sw_ff   <= ~switch_raw[7:4];
      end
      if (cmd.load) begin
         byte_ff      <= byte_in;
         port_ff      <= cmd.out_idx > LAST_HOST_OUT;
         last_ff      <= cmd.last;
         out_relay_ff <= relay_ff;
         out_volt_ff  <= volt_ff;
         out_curr_ff  <= curr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff <= RELAY_RESET;
         volt_ff  <= '0;
         curr_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            relay_ff <= relay_in;
            volt_ff  <= volt_in;
            curr_ff  <= curr_in;
         end
         if (cmd.load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !valid_ff || rsp.ready;
   assign status.has_src  = src_ff != SRC_NONE;

   assign rsp.valid            = valid_ff;
   assign rsp.tx_byte          = byte_ff;
   assign rsp.tx_port          = port_ff;
   assign rsp.last_byte        = last_ff;
   assign rsp.relay_bits       = out_relay_ff;
   assign rsp.voltage_setpoint = out_volt_ff;
   assign rsp.current_setpoint = out_curr_ff;

endmodule
`default_nettype wire

// ===== rtl/hfch_ctrl.sv =====
// Receive/timeout tracking and reply sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module hfch_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [7:0]                csr_wdata,
   hfch_req_if.sink                       req,
   input  wire hfch_pkg::hfch_status_type status,
   output      hfch_pkg::hfch_cmd_type    cmd
);
   import hfch_pkg::*;

   localparam logic STATE_RX   = 1'b0;
   localparam logic STATE_EMIT = 1'b1;

   logic             state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       ticks_ff, ticks_in;
   logic [7:0]       timeout_ff;
   logic [OUT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic [7:0]       ticks_sat;

   assign req.ready = state_ff == STATE_RX;
   assign accept    = req.valid && req.ready;
   assign ticks_sat = (ticks_ff == 8'hFF) ? ticks_ff : ticks_ff + 8'd1;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      ticks_in    = ticks_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.wr_idx  = idx_ff;
      cmd.out_idx = cnt_ff;
      cmd.last    = cnt_ff == (status.has_src ? LAST_SRC_OUT : LAST_HOST_OUT);
      case (state_ff)
         STATE_RX: begin
            if (accept) begin
               if (req.req_type) begin
                  if (phase_ff) begin
                     ticks_in = ticks_sat;
                     if (ticks_sat > timeout_ff) begin
                        phase_in = 1'b0;
                        idx_in   = '0;
                        ticks_in = '0;
                     end
                  end
               end else if (!phase_ff) begin
                  if (req.rx_byte == START_BYTE) begin
                     cmd.start = 1'b1;
                     idx_in    = IDX_W'(1);
                     ticks_in  = '0;
                     phase_in  = 1'b1;
                  end
               end else begin
                  ticks_in  = '0;
                  cmd.store = 1'b1;
                  if (idx_ff == LAST_FRAME_IDX) begin
                     cmd.finish = 1'b1;
                     idx_in     = '0;
                     phase_in   = 1'b0;
                     cnt_in     = '0;
                     state_in   = STATE_EMIT;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end
         STATE_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (cmd.last) begin
                  state_in = STATE_RX;
               end else begin
                  cnt_in = cnt_ff + OUT_W'(1);
               end
            end
         end
         default: state_in = STATE_RX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_RX;
         phase_ff   <= 1'b0;
         idx_ff     <= '0;
         ticks_ff   <= '0;
         cnt_ff     <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         ticks_ff <= ticks_in;
         cnt_ff   <= cnt_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   a_finish_to_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == STATE_EMIT && cnt_ff == '0)
      else $error("frame completion did not start the reply");

   a_load_only_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == STATE_EMIT && status.out_free)
      else $error("reply byte loaded outside reply sequencing");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_SRC_OUT)
      else $error("reply counter out of range");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.load && cmd.last |=> state_ff == STATE_RX)
      else $error("final reply byte did not return to receive");

endmodule
`default_nettype wire

// ===== rtl/host_frame_command_handler.sv =====
// Top level: host frame command handler.
// The request holding byte 15 of a frame is followed by the first response through the state
// and output registers, then one response per cycle while rsp_if.ready is high.
// Throughput: one request per cycle while a frame collects; after the final frame byte
// req_if.ready stays low for 16 (host reply) or 27 (host reply plus source command) loads.
// Reset (synchronous): idle, relay bits 0x08, setpoints 0, timeout 5; frame store not cleared.
`timescale 1ns / 1ps
`default_nettype none
module host_frame_command_handler (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   hfch_req_if.sink        req_if,
   hfch_rsp_if.source      rsp_if
);
   import hfch_pkg::*;

   hfch_cmd_type    cmd;
   hfch_status_type status;

   hfch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_if),
      .status    (status),
      .cmd       (cmd)
   );

   hfch_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_if.rx_byte),
      .switch_raw (req_if.switch_raw),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp_if)
   );

endmodule
`default_nettype wire

// ===== tb/tb_host_frame_command_handler.sv =====
// Testbench for host_frame_command_handler: directed frame table, then random traffic.
`timescale 1ns / 1ps
module tb_host_frame_command_handler;
   import hfch_pkg::*;

   localparam int   CYCLE_LIMIT = 400000;
   localparam logic PORT_HOST   = 1'b0;
   localparam logic PORT_SRC    = 1'b1;

   typedef enum logic {ITEM_BYTE = 1'b0, ITEM_TICK = 1'b1} item_kind_type;
   typedef enum {ROW_FRAME, ROW_JUNK, ROW_TICKS, ROW_DROP} row_kind_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_port;
      logic        last_byte;
      logic [5:0]  relay;
      logic [15:0] volt;
      logic [15:0] curr;
   } tx_entry_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]  code;
      logic [7:0]  seq;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [7:0]  fill;
      logic [7:0]  sw;
      int          ticks;
      bit          known;
      logic [5:0]  relay;
      logic [15:0] volt;
      logic [15:0] curr;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [7:0] csr_wdata;

   hfch_req_if req_if ();
   hfch_rsp_if rsp_if ();

   host_frame_command_handler DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   // enable / disable command sent on the source link
   logic [7:0] src_on_seq [11] = '{8'h02, 8'h45, 8'h4E, 8'h42, 8'h4C, 8'h20,
                                  8'h31, 8'h3B, 8'h53, 8'h0D, 8'h0A};
   logic [7:0] src_off_seq [11] = '{8'h02, 8'h45, 8'h4E, 8'h42, 8'h4C, 8'h20,
                                   8'h30, 8'h3B, 8'h54, 8'h0D, 8'h0A};
   logic [7:0] cmd_codes [11] = '{CODE_D5, CODE_D6, CODE_B1, CODE_B2, CODE_B3, CODE_A9,
                                 CODE_AA, CODE_C2, CODE_C3, CODE_C4, CODE_C5};

   row_type plan [20] = '{
      '{ROW_FRAME, CODE_D6, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_D5, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_D5, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_B1, 8'h02, 8'h00, 8'h00, 8'h55, 8'h00, 0, 1'b1, 6'h09, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_B2, 8'h03, 8'h00, 8'h00, 8'hAA, 8'h00, 0, 1'b1, 6'h0A, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_A9, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h0E, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_B3, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h0C, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_AA, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_C4, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h38, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_C5, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'h0000, 16'h0000},
      '{ROW_FRAME, CODE_C2, 8'h09, 8'hFF, 8'hFF, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'hFFFF, 16'h0000},
      '{ROW_FRAME, CODE_C3, 8'h0A, 8'hFF, 8'hFF, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'hFFFF, 16'hFFFF},
      '{ROW_FRAME, CODE_C2, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'h0000, 16'hFFFF},
      '{ROW_FRAME, CODE_C3, 8'h0C, 8'h12, 8'h34, 8'h00, 8'h00, 0, 1'b1, 6'h08, 16'h0000, 16'h1234},
      '{ROW_JUNK,  8'h00,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_JUNK,  8'hFF,   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_TICKS, 8'h00,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_FRAME, 8'h00,   8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'h00, 0, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_DROP,  CODE_B1, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 6, 1'b0, 6'h00, 16'h0000, 16'h0000},
      '{ROW_FRAME, 8'hFF,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1'b1, 6'h08, 16'h0000, 16'h1234}
   };

   // link model state
   logic             link_active;
   logic [IDX_W-1:0] frame_pos;
   logic [7:0]       frame_buf [FRAME_BYTES];
   logic [7:0]       quiet_ticks;
   logic [5:0]       relay_state;
   logic [15:0]      volt_set;
   logic [15:0]      curr_set;
   logic [7:0]       timeout_cfg;

   tx_entry_type tx_due [$];
   int        errors;
   int        cycles;
   int        req_idle_pct;
   int        rsp_idle_pct;
   int        hold_len;
   int        hold_left;
   logic      hold_toggle;
   logic      hold_seen;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      if (errors < 40) begin
         $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
      end
      errors++;
   endtask

   task automatic queue_reply(input logic [7:0] b, input logic port, input logic last);
      tx_entry_type e;
      e.tx_byte   = b;
      e.tx_port   = port;
      e.last_byte = last;
      e.relay     = relay_state;
      e.volt      = volt_set;
      e.curr      = curr_set;
      tx_due.push_back(e);
   endtask

   task automatic handle_link_item(input item_kind_type kind, input logic [7:0] b,
                                   input logic [7:0] sw, output int n);
      logic [7:0] pkt [FRAME_BYTES];
      logic [7:0] code;
      logic [1:0] src;
      n = 0;
      if (kind == ITEM_TICK) begin
         if (link_active) begin
            if (quiet_ticks != 8'hFF) quiet_ticks++;
            if (quiet_ticks > timeout_cfg) begin
               link_active = 1'b0;
               frame_pos   = '0;
               quiet_ticks = '0;
            end
         end
      end else if (!link_active) begin
         if (b == START_BYTE) begin
            frame_buf[0] = START_BYTE;
            frame_pos    = IDX_W'(1);
            quiet_ticks  = '0;
            link_active  = 1'b1;
         end
      end else begin
         quiet_ticks          = '0;
         frame_buf[frame_pos] = b;
         if (frame_pos != LAST_FRAME_IDX) begin
            frame_pos++;
         end else begin
            frame_pos   = '0;
            link_active = 1'b0;
            code        = frame_buf[CODE_IDX];
            src         = SRC_NONE;
            if (code == CODE_D5 || code == CODE_D6) begin
               for (int i = 0; i < FRAME_BYTES; i++) pkt[i] = 8'h00;
               pkt[0] = START_BYTE;
               pkt[1] = LEN_BYTE;
               pkt[2] = frame_buf[SEQ_IDX];
               if (code == CODE_D5) pkt[5] = {4'h0, ~sw[7:4]};
               else pkt[3] = CODE_D6;
               pkt[FLAG_IDX]        = FLAG_BYTE;
               pkt[FRAME_BYTES - 1] = END_BYTE;
            end else begin
               frame_buf[FLAG_IDX] = FLAG_BYTE;
               for (int i = 0; i < FRAME_BYTES; i++) pkt[i] = frame_buf[i];
               case (code)
                  CODE_B1: relay_state[1:0] = 2'b01;
                  CODE_B2: relay_state[1:0] = 2'b10;
                  CODE_B3: relay_state[1:0] = 2'b00;
                  CODE_A9: relay_state[2] = 1'b1;
                  CODE_AA: relay_state[2] = 1'b0;
                  CODE_C4: begin
                     relay_state[5:4] = 2'b11;
                     src = SRC_ON;
                  end
                  CODE_C5: begin
                     relay_state[5:4] = 2'b00;
                     src = SRC_OFF;
                  end
                  CODE_C2: volt_set = {frame_buf[HI_IDX], frame_buf[LO_IDX]};
                  CODE_C3: curr_set = {frame_buf[HI_IDX], frame_buf[LO_IDX]};
                  default: ;
               endcase
            end
            for (int i = 0; i < FRAME_BYTES; i++) begin
               queue_reply(pkt[i], PORT_HOST, i == FRAME_BYTES - 1 && src == SRC_NONE);
            end
            n = FRAME_BYTES;
            if (src != SRC_NONE) begin
               for (int i = 0; i < SRC_BYTES; i++) begin
                  queue_reply(src == SRC_ON ? src_on_seq[i] : src_off_seq[i], PORT_SRC,
                              i == SRC_BYTES - 1);
               end
               n = FRAME_BYTES + SRC_BYTES;
            end
         end
      end
   endtask

   task automatic push_item(input item_kind_type kind, input logic [7:0] b,
                            input logic [7:0] sw, output int n);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.rx_byte    <= b;
      req_if.switch_raw <= sw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      handle_link_item(kind, b, sw, n);
   endtask

   task automatic send_ticks(input int count);
      int n;
      for (int i = 0; i < count; i++) begin
         push_item(ITEM_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), n);
      end
   endtask

   task automatic send_frame(input logic [127:0] body, input logic [7:0] sw,
                             input int ticks, output int n);
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (i == 8) send_ticks(ticks);
         push_item(ITEM_BYTE, body[i*8 +: 8],
                   i == FRAME_BYTES - 1 ? sw : 8'($urandom_range(255)), n);
      end
   endtask

   function automatic logic [127:0] make_body(input logic [7:0] seq, input logic [7:0] code,
                                              input logic [7:0] hi, input logic [7:0] lo,
                                              input logic [7:0] fill);
      logic [127:0] body;
      body = {FRAME_BYTES{fill}};
      body[7:0]   = START_BYTE;
      body[15:8]  = LEN_BYTE;
      body[23:16] = seq;
      body[31:24] = code;
      body[39:32] = hi;
      body[47:40] = lo;
      return body;
   endfunction

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tx_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      timeout_cfg = value;
   endtask

   task automatic run_random(input int budget);
      logic [127:0] body;
      int used;
      int pick;
      int k;
      int ticks;
      int n;
      logic [7:0] b;
      used = 0;
      while (used < budget) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            for (int i = 1; i < FRAME_BYTES; i++) begin
               body[i*8 +: 8] = ($urandom_range(7) == 0) ? START_BYTE : 8'($urandom_range(255));
            end
            body[7:0] = START_BYTE;
            if ($urandom_range(9) != 0) body[31:24] = cmd_codes[$urandom_range(10)];
            ticks = 0;
            if (timeout_cfg != 0 && $urandom_range(3) == 0) begin
               ticks = $urandom_range(timeout_cfg > 6 ? 6 : timeout_cfg);
            end
            send_frame(body, 8'($urandom_range(255)), ticks, n);
            used += FRAME_BYTES;
         end else if (pick < 87) begin
            k = $urandom_range(1, 14);
            push_item(ITEM_BYTE, START_BYTE, 8'($urandom_range(255)), n);
            for (int i = 0; i < k; i++) begin
               push_item(ITEM_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)), n);
            end
            if (timeout_cfg == 8'hFF) begin
               // never dropped: finish the frame after a short silence
               send_ticks(3);
               for (int i = k + 1; i < FRAME_BYTES; i++) begin
                  push_item(ITEM_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)), n);
               end
            end else begin
               send_ticks(timeout_cfg + 1);
            end
            used += k + 1;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom_range(255));
               if (b == START_BYTE) b = 8'h00;
               push_item(ITEM_BYTE, b, 8'($urandom_range(255)), n);
            end
            send_ticks($urandom_range(3));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         hold_seen    <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen    <= hold_toggle;
         hold_left    <= hold_len;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_tx
      tx_entry_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (tx_due.size() == 0) begin
            report("unexpected response, tx_byte", 16'(rsp_if.tx_byte), 16'h0);
         end else begin
            want = tx_due.pop_front();
            if (rsp_if.tx_byte !== want.tx_byte) begin
               report("tx_byte", 16'(rsp_if.tx_byte), 16'(want.tx_byte));
            end
            if (rsp_if.tx_port !== want.tx_port) begin
               report("tx_port", 16'(rsp_if.tx_port), 16'(want.tx_port));
            end
            if (rsp_if.last_byte !== want.last_byte) begin
               report("last_byte", 16'(rsp_if.last_byte), 16'(want.last_byte));
            end
            if (rsp_if.relay_bits !== want.relay) begin
               report("relay_bits", 16'(rsp_if.relay_bits), 16'(want.relay));
            end
            if (rsp_if.voltage_setpoint !== want.volt) begin
               report("voltage_setpoint", rsp_if.voltage_setpoint, want.volt);
            end
            if (rsp_if.current_setpoint !== want.curr) begin
               report("current_setpoint", rsp_if.current_setpoint, want.curr);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_host_frame_command_handler failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [127:0] body;
      tx_entry_type e;
      int n;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = 8'h00;
      req_if.valid      = 1'b0;
      req_if.req_type   = 1'b0;
      req_if.rx_byte    = 8'h00;
      req_if.switch_raw = 8'h00;
      errors            = 0;
      cycles            = 0;
      hold_len          = 0;
      hold_toggle       = 1'b0;
      req_idle_pct      = 22;
      rsp_idle_pct      = 71;
      link_active       = 1'b0;
      frame_pos         = '0;
      quiet_ticks       = '0;
      relay_state       = RELAY_RESET;
      volt_set          = '0;
      curr_set          = '0;
      timeout_cfg       = TIMEOUT_RESET;
      for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'h00;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         case (plan[r].kind)
            ROW_FRAME: begin
               body = make_body(plan[r].seq, plan[r].code, plan[r].hi, plan[r].lo, plan[r].fill);
               send_frame(body, plan[r].sw, plan[r].ticks, n);
               if (plan[r].known) begin
                  for (int i = tx_due.size() - n; i < tx_due.size(); i++) begin
                     e       = tx_due[i];
                     e.relay = plan[r].relay;
                     e.volt  = plan[r].volt;
                     e.curr  = plan[r].curr;
                     tx_due[i] = e;
                  end
               end
            end
            ROW_JUNK: push_item(ITEM_BYTE, plan[r].code, plan[r].sw, n);
            ROW_TICKS: send_ticks(plan[r].ticks);
            ROW_DROP: begin
               body = make_body(plan[r].seq, plan[r].code, plan[r].hi, plan[r].lo, plan[r].fill);
               for (int i = 0; i < 6; i++) push_item(ITEM_BYTE, body[i*8 +: 8], plan[r].sw, n);
               send_ticks(plan[r].ticks);
            end
            default: ;
         endcase
      end

      drain();
      set_timeout(8'd0);
      run_random(8);

      drain();
      set_timeout(8'hFF);
      req_idle_pct = 71;
      rsp_idle_pct <= 22;
      run_random(8);

      drain();
      set_timeout(8'($urandom_range(1, 8)));
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      // long receiver stall while two frames are offered back to back
      hold_len    <= 300;
      hold_toggle <= ~hold_toggle;
      body = make_body(8'($urandom_range(255)), CODE_C4, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
      send_frame(body, 8'($urandom_range(255)), 0, n);
      body[31:24] = CODE_C5;
      send_frame(body, 8'($urandom_range(255)), 0, n);
      run_random(8);

      drain();
      if (tx_due.size() != 0) report("responses still expected", 16'(tx_due.size()), 16'h0);
      if (errors == 0) begin
         $display("tb_host_frame_command_handler passed");
      end else begin
         $display("tb_host_frame_command_handler failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hfch_pkg.sv
rtl/hfch_req_if.sv
rtl/hfch_rsp_if.sv
rtl/hfch_datapath.sv
rtl/hfch_ctrl.sv
rtl/host_frame_command_handler.sv
tb/tb_host_frame_command_handler.sv
